// File: design/plda_llr_score_assert.svh
// assertion macros used by the checker file of the plda llr scorer
`ifndef PLDA_LLR_SCORE_ASSERT_SVH
`define PLDA_LLR_SCORE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while reset is held
`define PLDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while reset is held
`define PLDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/plda_pkg.sv
// shared constants and types of the plda llr scorer
`timescale 1ns / 1ps

package plda_pkg;

    localparam int PLDA_DIM_MAX = 256;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SCORE = 1'b1;

    // radix-2 divider: one quotient bit per cycle
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = 7;

    // ln(2) in Q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [47:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

// File: design/plda_ram.sv
// generic single-write, registered-read ram
`timescale 1ns / 1ps

module plda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/plda_div.sv
// restoring radix-2 divider, 64-bit dividend by 48-bit divisor
`timescale 1ns / 1ps

module plda_div import plda_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [47:0]          rem_reg;
    logic [63:0]          quo_reg;
    logic [47:0]          divisor_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    logic [48:0] trial;
    logic [49:0] diff;
    logic        borrow;

    assign trial  = {rem_reg, quo_reg[63]};
    assign diff   = {1'b0, trial} - {2'b00, divisor_reg};
    assign borrow = diff[49];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (req.start) begin
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= borrow ? trial[47:0] : diff[47:0];
            quo_reg <= {quo_reg[62:0], ~borrow};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: design/plda_llr_score.sv
// Diagonal PLDA log-likelihood-ratio scorer. A load item (cmd 0) writes one psi entry
// into the table and leaves s_ready high. A score item (cmd 1) adds one dimension's
// term to the accumulator. Its work is four divisions on the shared 64-step radix-2
// divider, each with a start state and a wait for done, and two natural logs of 16
// squaring steps each on the shared 32x32 multiplier, each log after a run of
// normalizing shifts, plus multiply and bookkeeping states. s_ready is low while
// a score item is in work. The item with last set emits -0.5 times the sum as Q16.16,
// saturated, and clears the accumulator. It waits in its final state only if the
// previous result has not yet been taken. Reading a psi entry that was never loaded
// gives an undefined score.
`timescale 1ns / 1ps

module plda_llr_score import plda_pkg::*; #(
    parameter int DIM_MAX = PLDA_DIM_MAX
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_dim_index,
    input  logic [31:0] s_psi_value,
    input  logic [31:0] s_train_value,
    input  logic [31:0] s_test_value,
    input  logic [12:0] s_num_examples,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_llr,
    output logic        m_saturated
);

    localparam int AW = $clog2(DIM_MAX);

    typedef enum logic [21:0] {
        ST_IDLE  = 22'h000001,
        ST_PSI   = 22'h000002,
        ST_MND   = 22'h000004,
        ST_DG    = 22'h000008,
        ST_WG    = 22'h000010,
        ST_MMEAN = 22'h000020,
        ST_DV    = 22'h000040,
        ST_WV    = 22'h000080,
        ST_MD2   = 22'h000100,
        ST_DT1   = 22'h000200,
        ST_WT1   = 22'h000400,
        ST_MX2   = 22'h000800,
        ST_DT2   = 22'h001000,
        ST_WT2   = 22'h002000,
        ST_LINIT = 22'h004000,
        ST_LNORM = 22'h008000,
        ST_LSQ   = 22'h010000,
        ST_LUPD  = 22'h020000,
        ST_LMUL  = 22'h040000,
        ST_LRES  = 22'h080000,
        ST_ACC   = 22'h100000,
        ST_FIN   = 22'h200000
    } state_t;

    localparam logic signed [49:0] ACC_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] ACC_MIN = 50'sh3_8000_0000_0000;

    state_t state_reg, state_next;

    logic               idx_ok_reg;
    logic [12:0]        n_reg;
    logic [31:0]        u_reg;
    logic [31:0]        x_reg;
    logic               last_reg;
    logic [31:0]        p_reg;
    logic [45:0]        d_reg;
    logic [31:0]        g_reg;
    logic [31:0]        dm_reg;
    logic [47:0]        v_reg;
    logic [31:0]        t1_reg;
    logic [31:0]        t2_reg;
    logic [47:0]        m_reg;
    logic [4:0]         e_reg;
    logic [20:0]        y_reg;
    logic [3:0]         cnt_reg;
    logic               ln_sel_reg;
    logic [20:0]        lnv_reg;
    logic [20:0]        lnw_reg;
    logic [63:0]        prod_reg;
    logic signed [47:0] acc_reg;
    logic               ovf_reg;
    logic               m_valid_reg;
    logic [31:0]        llr_reg;
    logic               sat_reg;

    logic        s_xfer;
    logic        idx_ok;
    logic        ram_we;
    logic [31:0] ram_rdata;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    logic [45:0]        d_calc;
    logic [32:0]        g_calc;
    logic [31:0]        u_mag;
    logic [31:0]        x_mag;
    logic [32:0]        mean;
    logic [33:0]        diff;
    logic [33:0]        diff_mag;
    logic [32:0]        w_val;
    logic [32:0]        sq_shift;
    logic               norm_done;
    logic signed [49:0] acc_sum;
    logic signed [47:0] acc_new;
    logic               acc_clamp;
    logic [48:0]        neg_acc;
    logic signed [48:0] half;
    logic               half_fits;
    logic [31:0]        llr_calc;
    logic               out_free;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign idx_ok  = (32'(s_dim_index) < DIM_MAX);
    assign ram_we  = s_xfer && (s_cmd == CMD_LOAD) && idx_ok;

    plda_ram #(
        .WIDTH(32),
        .DEPTH(DIM_MAX)
    ) u_psi_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(AW'(s_dim_index)),
        .wdata(s_psi_value),
        .re   (s_xfer),
        .raddr(AW'(s_dim_index)),
        .rdata(ram_rdata)
    );

    plda_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    // datapath helpers
    assign d_calc   = prod_reg[45:0] + 46'h10000;
    assign g_calc   = 33'h1_0000_0000 - div_rsp.quotient[32:0];
    assign u_mag    = u_reg[31] ? (~u_reg + 32'd1) : u_reg;
    assign x_mag    = x_reg[31] ? (~x_reg + 32'd1) : x_reg;
    assign mean     = u_reg[31] ? (~{1'b0, prod_reg[63:32]} + 33'd1) : {1'b0, prod_reg[63:32]};
    assign diff     = {{2{x_reg[31]}}, x_reg} - {mean[32], mean};
    assign diff_mag = diff[33] ? (~diff + 34'd1) : diff;
    assign w_val    = 33'h1_0000 + {1'b0, p_reg};
    assign sq_shift = prod_reg[63:31];
    assign norm_done = (m_reg[47:32] == 16'd0) && m_reg[31];
    assign mul_p    = mul_a * mul_b;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MND: begin
                mul_a = {19'd0, n_reg};
                mul_b = p_reg;
            end
            ST_MMEAN: begin
                mul_a = u_mag;
                mul_b = g_reg;
            end
            ST_MD2: begin
                mul_a = dm_reg;
                mul_b = dm_reg;
            end
            ST_MX2: begin
                mul_a = x_mag;
                mul_b = x_mag;
            end
            ST_LSQ: begin
                mul_a = m_reg[31:0];
                mul_b = m_reg[31:0];
            end
            ST_LMUL: begin
                mul_a = {11'd0, y_reg};
                mul_b = LN2_Q32;
            end
            default: begin
            end
        endcase
    end

    // shared divider request
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            ST_DG: begin
                div_req.start    = 1'b1;
                div_req.dividend = 64'h0001_0000_0000_0000;
                div_req.divisor  = {2'b00, d_calc};
            end
            ST_DV: begin
                div_req.start    = 1'b1;
                div_req.dividend = {1'b0, p_reg, 31'd0};
                div_req.divisor  = {2'b00, d_reg};
            end
            ST_DT1: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = v_reg;
            end
            ST_DT2: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = {15'd0, w_val};
            end
            default: begin
            end
        endcase
    end

    // accumulate with clamp, then halve and negate for the result
    always_comb begin
        acc_sum = {{2{acc_reg[47]}}, acc_reg} + {29'd0, lnv_reg} + {18'd0, t1_reg}
                  - {29'd0, lnw_reg} - {18'd0, t2_reg};
        acc_clamp = 1'b0;
        acc_new   = acc_sum[47:0];
        if (acc_sum > ACC_MAX) begin
            acc_new   = ACC_MAX[47:0];
            acc_clamp = 1'b1;
        end else if (acc_sum < ACC_MIN) begin
            acc_new   = ACC_MIN[47:0];
            acc_clamp = 1'b1;
        end
        neg_acc   = ~{acc_reg[47], acc_reg} + 49'd1;
        half      = $signed(neg_acc) >>> 1;
        half_fits = (half[48:31] == {18{half[31]}});
        if (half_fits) begin
            llr_calc = half[31:0];
        end else if (half[48]) begin
            llr_calc = 32'h8000_0000;
        end else begin
            llr_calc = 32'h7FFF_FFFF;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_cmd == CMD_SCORE)) begin
                    state_next = ST_PSI;
                end
            end
            ST_PSI:   state_next = ST_MND;
            ST_MND:   state_next = ST_DG;
            ST_DG:    state_next = ST_WG;
            ST_WG: begin
                if (div_rsp.done) begin
                    state_next = ST_MMEAN;
                end
            end
            ST_MMEAN: state_next = ST_DV;
            ST_DV:    state_next = ST_WV;
            ST_WV: begin
                if (div_rsp.done) begin
                    state_next = ST_MD2;
                end
            end
            ST_MD2:   state_next = ST_DT1;
            ST_DT1:   state_next = ST_WT1;
            ST_WT1: begin
                if (div_rsp.done) begin
                    state_next = ST_MX2;
                end
            end
            ST_MX2:   state_next = ST_DT2;
            ST_DT2:   state_next = ST_WT2;
            ST_WT2: begin
                if (div_rsp.done) begin
                    state_next = ST_LINIT;
                end
            end
            ST_LINIT: state_next = ST_LNORM;
            ST_LNORM: begin
                if (norm_done) begin
                    state_next = ST_LSQ;
                end
            end
            ST_LSQ:   state_next = ST_LUPD;
            ST_LUPD: begin
                state_next = (cnt_reg == 4'd15) ? ST_LMUL : ST_LSQ;
            end
            ST_LMUL:  state_next = ST_LRES;
            ST_LRES: begin
                state_next = ln_sel_reg ? ST_ACC : ST_LINIT;
            end
            ST_ACC: begin
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            ln_sel_reg  <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    ln_sel_reg <= 1'b0;
                end
                ST_LNORM: begin
                    cnt_reg <= '0;
                end
                ST_LUPD: begin
                    cnt_reg <= cnt_reg + 4'd1;
                end
                ST_LRES: begin
                    ln_sel_reg <= 1'b1;
                end
                ST_ACC: begin
                    acc_reg <= acc_new;
                    if (acc_clamp) begin
                        ovf_reg <= 1'b1;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        acc_reg <= '0;
                        ovf_reg <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    idx_ok_reg <= idx_ok;
                    n_reg      <= s_num_examples;
                    u_reg      <= s_train_value;
                    x_reg      <= s_test_value;
                    last_reg   <= s_last;
                end
            end
            ST_PSI: begin
                p_reg <= idx_ok_reg ? ram_rdata : 32'd0;
            end
            ST_DG: begin
                d_reg <= d_calc;
            end
            ST_WG: begin
                g_reg <= g_calc[31:0];
            end
            ST_DV: begin
                dm_reg <= diff_mag[31:0];
            end
            ST_WV: begin
                v_reg <= 48'h8000_0000 + div_rsp.quotient[47:0];
            end
            ST_WT1: begin
                t1_reg <= div_rsp.quotient[32:1];
            end
            ST_WT2: begin
                t2_reg <= div_rsp.quotient[47:16];
            end
            ST_LINIT: begin
                m_reg <= ln_sel_reg ? {15'd0, w_val} : v_reg;
                e_reg <= ln_sel_reg ? 5'd15 : 5'd0;
            end
            ST_LNORM: begin
                // bring the leading one to bit 31, tracking the exponent
                if (m_reg[47:32] != 16'd0) begin
                    m_reg <= m_reg >> 1;
                    e_reg <= e_reg + 5'd1;
                end else if (!m_reg[31]) begin
                    m_reg <= m_reg << 1;
                    e_reg <= e_reg - 5'd1;
                end else begin
                    y_reg <= {e_reg, 16'd0};
                end
            end
            ST_LUPD: begin
                // one fraction bit of log2 per squaring
                if (sq_shift[32]) begin
                    m_reg          <= {16'd0, sq_shift[32:1]};
                    y_reg[~cnt_reg] <= 1'b1;
                end else begin
                    m_reg <= {16'd0, sq_shift[31:0]};
                end
            end
            ST_LRES: begin
                if (ln_sel_reg) begin
                    lnw_reg <= prod_reg[52:32];
                end else begin
                    lnv_reg <= prod_reg[52:32];
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    llr_reg <= llr_calc;
                    sat_reg <= ovf_reg || !half_fits;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_llr       = llr_reg;
    assign m_saturated = sat_reg;

endmodule

// File: design/plda_chk.sv
// port-level checker for the plda llr scorer, bound to the top level
`timescale 1ns / 1ps
`include "plda_llr_score_assert.svh"

module plda_chk import plda_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_cmd,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_llr,
    input logic        m_saturated
);

    // a waiting result holds
    `PLDA_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_llr) && $stable(m_saturated), "result changed while stalled")

    // a score transfer makes the block busy
    `PLDA_ASSERT_NXT(a_score_busy, s_valid && s_ready && (s_cmd == CMD_SCORE), !s_ready, "ready after score transfer")

    // a table load leaves the block ready in the next cycle
    `PLDA_ASSERT_NXT(a_load_quick, s_valid && s_ready && (s_cmd == CMD_LOAD), s_ready, "not ready after load transfer")

    // a result only appears at the end of a score item
    `PLDA_ASSERT_IMP(a_out_source, $rose(m_valid), !$past(s_ready), "result without score in work")

endmodule

bind plda_llr_score plda_chk u_plda_chk (.*);
